// ===== rtl/las_pkg.sv =====
// Package for the lock actuator sequencer: payload structs, codes and widths.
// Used by rtl/lock_actuator_sequencer_unit.sv and the bench; depends on nothing else.
package las_pkg;

    // field and register widths
    localparam int unsigned FORCE_W  = 10;
    localparam int unsigned TMO_W    = 15;
    localparam int unsigned PERIOD_W = 8;
    localparam int unsigned TIME_W   = 17;
    localparam int unsigned RTIME_W  = 18;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_FWD   = 2'd1;
    localparam logic [1:0] CMD_BWD   = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // travel direction codes, same values as the start commands
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    // status codes
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_FWD      = 3'd1;
    localparam logic [2:0] ST_BWD      = 3'd2;
    localparam logic [2:0] ST_LOCKED   = 3'd3;
    localparam logic [2:0] ST_UNLOCKED = 3'd4;
    localparam logic [2:0] ST_ERROR    = 3'd5;
    localparam logic [2:0] ST_CALIB    = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_THRESH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BWD_THRESH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TMO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_TMO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PERIOD  = 3'd5;

    // configuration reset values
    localparam logic [FORCE_W-1:0]  FWD_THRESH_RST  = 10'd465;
    localparam logic [FORCE_W-1:0]  BWD_THRESH_RST  = 10'd465;
    localparam logic [TMO_W-1:0]    TRAVEL_TMO_RST  = 15'd3000;
    localparam logic [TMO_W-1:0]    CENTRE_TMO_RST  = 15'd3000;
    localparam logic [PERIOD_W-1:0] NORM_PERIOD_RST = 8'd100;
    localparam logic [PERIOD_W-1:0] CAL_PERIOD_RST  = 8'd10;

    // calibration phase
    typedef enum logic [2:0] {
        CAL_IDLE    = 3'b001,
        CAL_LEG_ONE = 3'b010,
        CAL_LEG_TWO = 3'b100
    } cal_phase_t;

    // return phase: start codes exist only within one item's update
    typedef enum logic [4:0] {
        RET_IDLE      = 5'b00001,
        RET_START_FWD = 5'b00010,
        RET_START_BWD = 5'b00100,
        RET_RUN_FWD   = 5'b01000,
        RET_RUN_BWD   = 5'b10000
    } ret_phase_t;

    // request payloads
    typedef struct packed {
        logic [1:0]         cmd;
        logic [FORCE_W-1:0] force_sample;
        logic               centre_seen;
    } las_in_t;

    typedef struct packed {
        logic                drive_forward;
        logic                drive_backward;
        logic                indicator;
        logic [2:0]          status;
        logic [PERIOD_W-1:0] period_now;
    } las_out_t;

endpackage

// ===== rtl/lock_actuator_sequencer_unit.sv =====
// Lock actuator sequencer top level: input stage, per-item update, result stage.
// Depends on rtl/las_pkg.sv for payload structs, codes and widths.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  in      | in_valid, in_ready, in_data               | request in
//  out     | out_valid, out_ready, out_data            | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// One request enters the input register per cycle while the output is not stalled;
// its result passes the update stage into the output register, raising out_valid.
// Throughput is one request per cycle without output stalls, set by the single
// update stage that reads and writes the sequencer state in the same cycle.
// Reset restores state, config and valid flags at once (no sweep), not the data regs.
// A stalled output holds the update stage, which in turn holds the input register.
module lock_actuator_sequencer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  las_pkg::las_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output las_pkg::las_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [las_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [las_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import las_pkg::*;

    // configuration registers
    logic [FORCE_W-1:0]  fwd_thresh_reg;
    logic [FORCE_W-1:0]  bwd_thresh_reg;
    logic [TMO_W-1:0]    travel_tmo_reg;
    logic [TMO_W-1:0]    centre_tmo_reg;
    logic [PERIOD_W-1:0] norm_period_reg;
    logic [PERIOD_W-1:0] cal_period_reg;

    // pipeline registers
    logic     in_valid_reg;
    las_in_t  in_item_reg;
    logic     out_valid_reg;
    las_out_t out_data_reg;
    logic     stage_fire;

    // sequencer state
    logic [1:0]                direction_reg,   direction_next;
    logic                      pending_reg,     pending_next;
    cal_phase_t                cal_phase_reg,   cal_phase_next;
    ret_phase_t                ret_phase_reg,   ret_phase_next;
    logic [TIME_W-1:0]         travel_time_reg, travel_time_next;
    logic [TIME_W-1:0]         cal_one_reg,     cal_one_next;
    logic [TIME_W-1:0]         cal_two_reg,     cal_two_next;
    logic signed [RTIME_W-1:0] ret_time_reg,    ret_time_next;
    logic [PERIOD_W-1:0]       tick_period_reg, tick_period_next;
    logic [1:0]                motor_reg,       motor_next;
    logic                      locked_reg,      locked_next;
    logic [2:0]                status_reg,      status_next;

    // saturating add of a period to a 17-bit time
    function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                   input logic [PERIOD_W-1:0] b);
        logic [TIME_W:0] sum;
        begin
            sum = {1'b0, a} + {{(TIME_W+1-PERIOD_W){1'b0}}, b};
            add_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        end
    endfunction

    // handshakes
    assign stage_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || stage_fire;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_thresh_reg  <= FWD_THRESH_RST;
            bwd_thresh_reg  <= BWD_THRESH_RST;
            travel_tmo_reg  <= TRAVEL_TMO_RST;
            centre_tmo_reg  <= CENTRE_TMO_RST;
            norm_period_reg <= NORM_PERIOD_RST;
            cal_period_reg  <= CAL_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FWD_THRESH:  fwd_thresh_reg  <= cfg_data[FORCE_W-1:0];
                CFG_BWD_THRESH:  bwd_thresh_reg  <= cfg_data[FORCE_W-1:0];
                CFG_TRAVEL_TMO:  travel_tmo_reg  <= cfg_data[TMO_W-1:0];
                CFG_CENTRE_TMO:  centre_tmo_reg  <= cfg_data[TMO_W-1:0];
                CFG_NORM_PERIOD: norm_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_CAL_PERIOD:  cal_period_reg  <= cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    // per-item state update
    always_comb
    begin
        logic [TIME_W:0]         two_tmo;
        logic signed [RTIME_W:0] ret_diff;
        logic                    ret_done;

        direction_next   = direction_reg;
        pending_next     = pending_reg;
        cal_phase_next   = cal_phase_reg;
        ret_phase_next   = ret_phase_reg;
        travel_time_next = travel_time_reg;
        cal_one_next     = cal_one_reg;
        cal_two_next     = cal_two_reg;
        ret_time_next    = ret_time_reg;
        tick_period_next = tick_period_reg;
        motor_next       = motor_reg;
        locked_next      = locked_reg;
        status_next      = status_reg;
        two_tmo          = {2'b00, centre_tmo_reg, 1'b0};
        ret_diff         = '0;
        ret_done         = 1'b0;

        if (in_item_reg.cmd == CMD_FWD || in_item_reg.cmd == CMD_BWD)
        begin
            // start request arms the centre check
            pending_next   = 1'b1;
            direction_next = in_item_reg.cmd;
            status_next    = (in_item_reg.cmd == CMD_FWD) ? ST_FWD : ST_BWD;
        end
        else if (in_item_reg.cmd == CMD_TICK)
        begin
            if (direction_reg != DIR_IDLE)
            begin
                if (pending_reg)
                begin
                    if (in_item_reg.centre_seen)
                    begin
                        // centre confirmed: drive the chosen motor
                        pending_next     = 1'b0;
                        tick_period_next = norm_period_reg;
                        if (cal_phase_reg != CAL_IDLE)
                        begin
                            motor_next     = 2'b00;
                            cal_phase_next = CAL_IDLE;
                            cal_one_next   = '0;
                            cal_two_next   = '0;
                            status_next    = (direction_reg == DIR_FWD) ? ST_FWD : ST_BWD;
                        end
                        motor_next = motor_next |
                                     ((direction_reg == DIR_FWD) ? 2'b01 : 2'b10);
                    end
                    else
                    begin
                        // calibration legs
                        if (cal_phase_next == CAL_IDLE)
                        begin
                            status_next      = ST_CALIB;
                            tick_period_next = cal_period_reg;
                            motor_next       = 2'b01;
                            cal_phase_next   = CAL_LEG_ONE;
                            cal_one_next     = '0;
                            cal_two_next     = '0;
                        end
                        if (cal_phase_next == CAL_LEG_ONE)
                        begin
                            cal_one_next = add_sat(cal_one_next, tick_period_next);
                            if (cal_one_next > {2'b00, centre_tmo_reg})
                            begin
                                cal_phase_next = CAL_LEG_TWO;
                                motor_next     = 2'b10;
                            end
                        end
                        if (cal_phase_next == CAL_LEG_TWO)
                        begin
                            cal_two_next = add_sat(cal_two_next, tick_period_next);
                            if ({1'b0, cal_two_next} > two_tmo)
                            begin
                                cal_phase_next = CAL_IDLE;
                                motor_next     = 2'b00;
                                status_next    = ST_ERROR;
                                direction_next = DIR_IDLE;
                            end
                        end
                    end
                end
                else
                begin
                    // travel: force stop
                    if (direction_reg == DIR_FWD &&
                        in_item_reg.force_sample > fwd_thresh_reg)
                    begin
                        locked_next      = 1'b1;
                        motor_next[0]    = 1'b0;
                        status_next      = ST_LOCKED;
                        ret_phase_next   = RET_START_BWD;
                        direction_next   = DIR_IDLE;
                        ret_time_next    = {1'b0, travel_time_reg};
                        travel_time_next = '0;
                    end
                    else if (direction_reg == DIR_BWD &&
                             in_item_reg.force_sample > bwd_thresh_reg)
                    begin
                        locked_next      = 1'b0;
                        motor_next[1]    = 1'b0;
                        status_next      = ST_UNLOCKED;
                        ret_phase_next   = RET_START_FWD;
                        direction_next   = DIR_IDLE;
                        ret_time_next    = {1'b0, travel_time_reg};
                        travel_time_next = '0;
                    end
                    // travel clock and timeout
                    travel_time_next = add_sat(travel_time_next, tick_period_reg);
                    if (direction_next != DIR_IDLE &&
                        travel_time_next >= {2'b00, travel_tmo_reg})
                    begin
                        motor_next       = 2'b00;
                        status_next      = ST_ERROR;
                        ret_phase_next   = (direction_next == DIR_FWD) ?
                                           RET_START_BWD : RET_START_FWD;
                        direction_next   = DIR_IDLE;
                        ret_time_next    = {1'b0, travel_time_next};
                        travel_time_next = '0;
                    end
                end
            end

            // return with the opposite motor
            if (ret_phase_next != RET_IDLE)
            begin
                if (ret_phase_next == RET_START_FWD)
                begin
                    motor_next[0]  = 1'b1;
                    ret_phase_next = RET_RUN_FWD;
                end
                if (ret_phase_next == RET_START_BWD)
                begin
                    motor_next[1]  = 1'b1;
                    ret_phase_next = RET_RUN_BWD;
                end
                ret_done = in_item_reg.centre_seen || ret_time_next[RTIME_W-1] ||
                           (ret_time_next == '0);
                if (ret_phase_next == RET_RUN_FWD && ret_done)
                begin
                    motor_next[0]  = 1'b0;
                    ret_phase_next = RET_IDLE;
                    ret_time_next  = '0;
                end
                if (ret_phase_next == RET_RUN_BWD && ret_done)
                begin
                    motor_next[1]  = 1'b0;
                    ret_phase_next = RET_IDLE;
                    ret_time_next  = '0;
                end
                if (ret_phase_next != RET_IDLE &&
                    (ret_time_next[RTIME_W-1] || ret_time_next == '0))
                begin
                    motor_next     = 2'b00;
                    status_next    = ST_ERROR;
                    ret_phase_next = RET_IDLE;
                    ret_time_next  = '0;
                end
                // return clock, saturating at the 18-bit limits
                ret_diff = {ret_time_next[RTIME_W-1], ret_time_next} -
                           $signed({{(RTIME_W+1-PERIOD_W){1'b0}}, tick_period_next});
                if (ret_diff[RTIME_W] && !ret_diff[RTIME_W-1])
                begin
                    ret_time_next = {1'b1, {(RTIME_W-1){1'b0}}};
                end
                else if (!ret_diff[RTIME_W] && ret_diff[RTIME_W-1])
                begin
                    ret_time_next = {1'b0, {(RTIME_W-1){1'b1}}};
                end
                else
                begin
                    ret_time_next = ret_diff[RTIME_W-1:0];
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= DIR_IDLE;
            pending_reg     <= 1'b0;
            cal_phase_reg   <= CAL_IDLE;
            ret_phase_reg   <= RET_IDLE;
            travel_time_reg <= '0;
            cal_one_reg     <= '0;
            cal_two_reg     <= '0;
            ret_time_reg    <= '0;
            tick_period_reg <= NORM_PERIOD_RST;
            motor_reg       <= 2'b00;
            locked_reg      <= 1'b0;
            status_reg      <= ST_UNLOCKED;
        end
        else if (stage_fire)
        begin
            direction_reg   <= direction_next;
            pending_reg     <= pending_next;
            cal_phase_reg   <= cal_phase_next;
            ret_phase_reg   <= ret_phase_next;
            travel_time_reg <= travel_time_next;
            cal_one_reg     <= cal_one_next;
            cal_two_reg     <= cal_two_next;
            ret_time_reg    <= ret_time_next;
            tick_period_reg <= tick_period_next;
            motor_reg       <= motor_next;
            locked_reg      <= locked_next;
            status_reg      <= status_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            out_data_reg.drive_forward  <= motor_next[0];
            out_data_reg.drive_backward <= motor_next[1];
            out_data_reg.indicator      <= locked_next;
            out_data_reg.status         <= status_next;
            out_data_reg.period_now     <= tick_period_next;
        end
    end

`ifndef NO_ASSERTIONS
    // an updated item always lands in the result register
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire |=> out_valid_reg)
        else $error("update stage fired without a result");

    // calibration only runs while the centre check is armed
    a_cal_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cal_phase_reg != CAL_IDLE) |-> pending_reg)
        else $error("calibrating without a pending centre check");

    // return start codes are resolved within the same update
    a_ret_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        (ret_phase_reg != RET_START_FWD) && (ret_phase_reg != RET_START_BWD))
        else $error("return start code left in state");

    // a stalled output holds the input stage
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input stage changed under a stalled output");
`endif

endmodule

// ===== bench/tb_lock_actuator_sequencer_unit.sv =====
`timescale 1ns / 100ps
// Testbench for lock_actuator_sequencer_unit: directed and random requests whose results are
// checked against an in-bench predictor of the two-motor sequencer.
// Depends on rtl/las_pkg.sv and rtl/lock_actuator_sequencer_unit.sv.
module tb_lock_actuator_sequencer_unit;
    import las_pkg::*;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int T17_TOP = 131071;
    localparam int T18_TOP = 131071;
    localparam int T18_BOT = -131072;
    localparam int PHASE_REQS = 50;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    las_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    las_out_t              out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    lock_actuator_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    // predictor copy of the registers
    logic [FORCE_W-1:0]  lim_fwd;
    logic [FORCE_W-1:0]  lim_bwd;
    logic [TMO_W-1:0]    travel_limit;
    logic [TMO_W-1:0]    centre_limit;
    logic [PERIOD_W-1:0] run_period;
    logic [PERIOD_W-1:0] search_period;

    // predictor copy of the sequencer state
    logic [1:0]          heading;
    logic                centre_check;
    cal_phase_t          search_leg;
    ret_phase_t          back_leg;
    int                  travel_ms;
    int                  leg_one_ms;
    int                  leg_two_ms;
    int                  back_ms;
    logic [PERIOD_W-1:0] period_cur;
    logic                motor_fwd;
    logic                motor_bwd;
    logic                locked;
    logic [2:0]          status_cur;

    las_in_t  lock_reqs[$];
    las_out_t due_outputs[$];
    int       mismatches = 0;
    int       results_seen = 0;

    function automatic void reset_sequencer();
        lim_fwd = FWD_THRESH_RST;
        lim_bwd = BWD_THRESH_RST;
        travel_limit = TRAVEL_TMO_RST;
        centre_limit = CENTRE_TMO_RST;
        run_period = NORM_PERIOD_RST;
        search_period = CAL_PERIOD_RST;
        heading = DIR_IDLE;
        centre_check = 1'b0;
        search_leg = CAL_IDLE;
        back_leg = RET_IDLE;
        travel_ms = 0;
        leg_one_ms = 0;
        leg_two_ms = 0;
        back_ms = 0;
        period_cur = NORM_PERIOD_RST;
        motor_fwd = 1'b0;
        motor_bwd = 1'b0;
        locked = 1'b0;
        status_cur = ST_UNLOCKED;
    endfunction

    function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                          input int unsigned val);
        case (idx)
            CFG_FWD_THRESH:  lim_fwd = val[FORCE_W-1:0];
            CFG_BWD_THRESH:  lim_bwd = val[FORCE_W-1:0];
            CFG_TRAVEL_TMO:  travel_limit = val[TMO_W-1:0];
            CFG_CENTRE_TMO:  centre_limit = val[TMO_W-1:0];
            CFG_NORM_PERIOD: run_period = val[PERIOD_W-1:0];
            CFG_CAL_PERIOD:  search_period = val[PERIOD_W-1:0];
            default:         ;
        endcase
    endfunction

    // 17-bit time counters stick at the top
    function automatic int sum17(input int a, input int b);
        int s;
        s = a + b;
        return (s > T17_TOP) ? T17_TOP : s;
    endfunction

    function automatic int clamp18(input int v);
        if (v > T18_TOP)
            return T18_TOP;
        if (v < T18_BOT)
            return T18_BOT;
        return v;
    endfunction

    // stop travel and arm the return on the opposite motor
    function automatic void finish_travel(input logic [2:0] st);
        status_cur = st;
        back_leg = (heading == DIR_FWD) ? RET_START_BWD : RET_START_FWD;
        heading = DIR_IDLE;
        back_ms = clamp18(travel_ms);
        travel_ms = 0;
    endfunction

    // centre confirmation, else calibration legs
    function automatic void seek_centre(input logic seen);
        if (seen)
        begin
            centre_check = 1'b0;
            period_cur = run_period;
            if (search_leg != CAL_IDLE)
            begin
                motor_fwd = 1'b0;
                motor_bwd = 1'b0;
                search_leg = CAL_IDLE;
                leg_one_ms = 0;
                leg_two_ms = 0;
                status_cur = (heading == DIR_FWD) ? ST_FWD : ST_BWD;
            end
            if (heading == DIR_FWD)
                motor_fwd = 1'b1;
            else
                motor_bwd = 1'b1;
            return;
        end
        if (search_leg == CAL_IDLE)
        begin
            status_cur = ST_CALIB;
            period_cur = search_period;
            motor_fwd = 1'b1;
            motor_bwd = 1'b0;
            search_leg = CAL_LEG_ONE;
            leg_one_ms = 0;
            leg_two_ms = 0;
        end
        if (search_leg == CAL_LEG_ONE)
        begin
            leg_one_ms = sum17(leg_one_ms, int'(period_cur));
            if (leg_one_ms > int'(centre_limit))
            begin
                search_leg = CAL_LEG_TWO;
                motor_fwd = 1'b0;
                motor_bwd = 1'b1;
            end
        end
        if (search_leg == CAL_LEG_TWO)
        begin
            leg_two_ms = sum17(leg_two_ms, int'(period_cur));
            if (leg_two_ms > 2 * int'(centre_limit))
            begin
                search_leg = CAL_IDLE;
                motor_fwd = 1'b0;
                motor_bwd = 1'b0;
                status_cur = ST_ERROR;
                heading = DIR_IDLE;
            end
        end
    endfunction

    // force stop or travel timeout
    function automatic void travel_step(input logic [FORCE_W-1:0] force_val);
        if (heading == DIR_FWD && force_val > lim_fwd)
        begin
            locked = 1'b1;
            motor_fwd = 1'b0;
            finish_travel(ST_LOCKED);
        end
        else if (heading == DIR_BWD && force_val > lim_bwd)
        begin
            locked = 1'b0;
            motor_bwd = 1'b0;
            finish_travel(ST_UNLOCKED);
        end
        travel_ms = sum17(travel_ms, int'(period_cur));
        if (heading != DIR_IDLE && travel_ms >= int'(travel_limit))
        begin
            motor_fwd = 1'b0;
            motor_bwd = 1'b0;
            finish_travel(ST_ERROR);
        end
    endfunction

    // return drive, ends on centre or when the travelled time is used up
    function automatic void return_step(input logic seen);
        if (back_leg == RET_START_FWD)
        begin
            motor_fwd = 1'b1;
            back_leg = RET_RUN_FWD;
        end
        if (back_leg == RET_START_BWD)
        begin
            motor_bwd = 1'b1;
            back_leg = RET_RUN_BWD;
        end
        if (back_leg == RET_RUN_FWD && (seen || back_ms <= 0))
        begin
            motor_fwd = 1'b0;
            back_leg = RET_IDLE;
            back_ms = 0;
        end
        if (back_leg == RET_RUN_BWD && (seen || back_ms <= 0))
        begin
            motor_bwd = 1'b0;
            back_leg = RET_IDLE;
            back_ms = 0;
        end
        if (back_leg != RET_IDLE && back_ms <= 0)
        begin
            motor_fwd = 1'b0;
            motor_bwd = 1'b0;
            status_cur = ST_ERROR;
            back_leg = RET_IDLE;
            back_ms = 0;
        end
        back_ms = clamp18(back_ms - int'(period_cur));
    endfunction

    // one request through the sequencer, giving the drive levels after it
    function automatic las_out_t step_sequencer(input las_in_t req);
        las_out_t res;
        if (req.cmd == CMD_FWD || req.cmd == CMD_BWD)
        begin
            centre_check = 1'b1;
            heading = req.cmd;
            status_cur = (req.cmd == CMD_FWD) ? ST_FWD : ST_BWD;
        end
        else if (req.cmd == CMD_TICK)
        begin
            if (heading != DIR_IDLE)
            begin
                if (centre_check)
                    seek_centre(req.centre_seen);
                else
                    travel_step(req.force_sample);
            end
            if (back_leg != RET_IDLE)
                return_step(req.centre_seen);
        end
        res.drive_forward = motor_fwd;
        res.drive_backward = motor_bwd;
        res.indicator = locked;
        res.status = status_cur;
        res.period_now = period_cur;
        return res;
    endfunction

    function automatic void push_req(input int unsigned cmd, input int unsigned force_val,
                                     input int unsigned centre);
        las_in_t r;
        r.cmd = cmd[1:0];
        r.force_sample = force_val[FORCE_W-1:0];
        r.centre_seen = centre[0];
        lock_reqs.push_back(r);
    endfunction

    // one lock or unlock attempt: start, optional calibration, travel, return, some noise
    function automatic int queue_session();
        int  n;
        int  limit;
        int  count;
        bit  go_fwd;
        n = 0;
        go_fwd = $urandom_range(0, 1);
        limit = go_fwd ? int'(lim_fwd) : int'(lim_bwd);
        push_req(go_fwd ? CMD_FWD : CMD_BWD, $urandom_range(0, 1023), $urandom_range(0, 1));
        n++;
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        repeat (count)
            push_req(CMD_TICK, $urandom_range(0, 1023), 0);
        n += count;
        if ($urandom_range(0, 9) != 0)
        begin
            push_req(CMD_TICK, $urandom_range(0, 1023), 1);
            n++;
        end
        count = $urandom_range(1, 24);
        repeat (count)
            push_req(CMD_TICK,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, limit),
                     $urandom_range(0, 5) == 0);
        n += count;
        count = $urandom_range(0, 12);
        repeat (count)
            push_req(CMD_TICK, $urandom_range(0, 1023), $urandom_range(0, 7) == 0);
        n += count;
        if ($urandom_range(0, 5) == 0)
        begin
            count = $urandom_range(1, 3);
            repeat (count)
                push_req($urandom_range(0, 3), $urandom_range(0, 1023), $urandom_range(0, 1));
            n += count;
        end
        return n;
    endfunction

    // request driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                due_outputs.push_back(step_sequencer(in_data));
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 || lock_reqs.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= lock_reqs.pop_front();
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // result receiver: stall pattern plus one long hold to back up the input
    int unsigned rx_cycle = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= 100 && lock_reqs.size() > 10)
        begin
            out_ready <= 1'b0;
            hold_left <= 120;
            hold_done <= 1'b1;
        end
        else if (rx_cycle[8:6] < 2)
            out_ready <= 1'b1;
        else if (rx_cycle[8:6] == 4)
            out_ready <= (rx_cycle[2:0] >= 3);
        else
            out_ready <= ($urandom_range(0, 2) != 0);
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        las_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (due_outputs.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d with none due: fwd=%0d bwd=%0d ind=%0d st=%0d per=%0d",
                             results_seen, out_data.drive_forward, out_data.drive_backward,
                             out_data.indicator, out_data.status, out_data.period_now);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = due_outputs.pop_front();
                if (out_data.drive_forward !== want.drive_forward ||
                    out_data.drive_backward !== want.drive_backward ||
                    out_data.indicator !== want.indicator ||
                    out_data.status !== want.status ||
                    out_data.period_now !== want.period_now)
                begin
                    if (mismatches < 10)
                        $display("result %0d: got fwd=%0d bwd=%0d ind=%0d st=%0d per=%0d, %s",
                                 results_seen, out_data.drive_forward, out_data.drive_backward,
                                 out_data.indicator, out_data.status, out_data.period_now,
                                 $sformatf("wanted fwd=%0d bwd=%0d ind=%0d st=%0d per=%0d",
                                           want.drive_forward, want.drive_backward,
                                           want.indicator, want.status, want.period_now));
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        load_register(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int unsigned fth, input int unsigned bth,
                              input int unsigned tt, input int unsigned ct,
                              input int unsigned np, input int unsigned cp);
        write_reg(CFG_FWD_THRESH, fth);
        write_reg(CFG_BWD_THRESH, bth);
        write_reg(CFG_TRAVEL_TMO, tt);
        write_reg(CFG_CENTRE_TMO, ct);
        write_reg(CFG_NORM_PERIOD, np);
        write_reg(CFG_CAL_PERIOD, cp);
    endtask

    // sender holds off until every due result is back
    task automatic wait_drained();
        while (lock_reqs.size() != 0 || in_valid || due_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase();
        int sent;
        sent = 0;
        while (sent < PHASE_REQS)
            sent += queue_session();
        wait_drained();
    endtask

    // reset, directed requests, then random phases under several register settings
    initial
    begin
        reset_sequencer();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // short centre timeout so a calibration fails within a few ticks
        set_config(465, 465, 3000, 15, 100, 10);
        push_req(CMD_NONE, 1023, 1);
        push_req(CMD_TICK, 0, 0);
        push_req(CMD_FWD, 512, 0);
        push_req(CMD_TICK, 0, 1);
        push_req(CMD_TICK, 0, 0);
        push_req(CMD_TICK, 1023, 0);
        // start while returning
        push_req(CMD_BWD, 0, 0);
        push_req(CMD_TICK, 0, 1);
        push_req(CMD_TICK, 465, 0);
        // force stop with centre already seen ends the return at once
        push_req(CMD_TICK, 466, 1);
        push_req(CMD_FWD, 0, 0);
        repeat (5)
            push_req(CMD_TICK, 341, 0);
        push_req(CMD_BWD, 1023, 1);
        push_req(CMD_TICK, 682, 0);
        push_req(CMD_TICK, 0, 1);
        push_req(CMD_TICK, 1023, 0);
        repeat (3)
            push_req(CMD_TICK, 0, 0);
        push_req(CMD_NONE, 0, 0);
        wait_drained();

        // extremes: lowest timeouts and forward limit, longest periods
        set_config(0, 1023, 1, 1, 255, 255);
        run_phase();
        // extremes: highest forward and travel limits, shortest periods
        set_config(1023, 0, 32767, 40, 1, 1);
        run_phase();
        // zero periods, plus writes to unused indexes
        set_config(300, 700, 500, 100, 0, 0);
        write_reg(CFG_SPARE_LO, $urandom_range(0, 32767));
        write_reg(CFG_SPARE_HI, $urandom_range(0, 32767));
        run_phase();
        set_config(465, 465, 32767, 32767, 255, 255);
        run_phase();
        set_config(465, 465, 3000, 3000, 100, 10);
        run_phase();
        repeat (2)
        begin
            set_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(1, 3000), $urandom_range(1, 150),
                       $urandom_range(1, 255), $urandom_range(5, 60));
            run_phase();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/las_pkg.sv
rtl/lock_actuator_sequencer_unit.sv
bench/tb_lock_actuator_sequencer_unit.sv
